### design/hrp_pkg.sv
// Package for the HTTP response header parser.
// Holds the parse phase, status and role codes, the character constants and
// the character-class functions. No dependencies.
package hrp_pkg;

    localparam int unsigned LIMIT_W = 24;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd65536;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SP    = 8'h20;
    localparam logic [7:0] CHAR_HT    = 8'h09;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;

    typedef enum logic [9:0] {
        PH_STATUS_START = 10'b00_0000_0001,
        PH_STATUS       = 10'b00_0000_0010,
        PH_LF_STATUS    = 10'b00_0000_0100,
        PH_LINE_START   = 10'b00_0000_1000,
        PH_LWS          = 10'b00_0001_0000,
        PH_NAME         = 10'b00_0010_0000,
        PH_SPACE        = 10'b00_0100_0000,
        PH_VALUE        = 10'b00_1000_0000,
        PH_LF_LINE      = 10'b01_0000_0000,
        PH_LF_END       = 10'b10_0000_0000
    } phase_t;

    typedef enum logic [1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_COMPLETE   = 2'd1,
        ST_MALFORMED  = 2'd2,
        ST_TOO_LARGE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ROLE_NONE       = 3'd0,
        ROLE_STATUS     = 3'd1,
        ROLE_NAME_FIRST = 3'd2,
        ROLE_NAME       = 3'd3,
        ROLE_VALUE      = 3'd4
    } role_t;

    // Outcome of one parse step, passed from the step logic to the top level.
    typedef struct packed {
        phase_t  phase;
        logic    header_seen;
        status_t status;
        role_t   role;
    } step_t;

    function automatic logic is_ctl(input logic [7:0] c);
        return (c <= 8'd31) || (c == CHAR_DEL);
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        logic hit;
        unique case (c)
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
            8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09:
                hit = 1'b1;
            default:
                hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Bytes with the top bit set are outside CHAR and never token bytes.
    function automatic logic is_token(input logic [7:0] c);
        return !c[7] && !is_ctl(c) && !is_sep(c);
    endfunction

endpackage

### design/hrp_if.sv
// Channel interfaces of the HTTP response header parser: input bytes,
// tagged results and the byte limit write channel. No dependencies.
interface hrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface hrp_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] parse_status;
    logic [2:0] byte_role;
    logic [7:0] byte_out;

    modport source (output valid, output parse_status, output byte_role, output byte_out,
                    input ready);
    modport sink (input valid, input parse_status, input byte_role, input byte_out,
                  output ready);
endinterface

interface hrp_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] byte_limit;

    modport source (output valid, output byte_limit, input ready);
    modport sink (input valid, input byte_limit, output ready);
endinterface

### design/hrp_step.sv
// Parse step of the HTTP response header parser: next phase, header flag,
// status and role for one byte. Depends on hrp_pkg.
module hrp_step (
    input  hrp_pkg::phase_t phase,
    input  logic            header_seen,
    input  logic [7:0]      c,
    output hrp_pkg::step_t  step
);
    import hrp_pkg::*;

    always_comb
    begin
        step.phase       = phase;
        step.header_seen = header_seen;
        step.status      = ST_INCOMPLETE;
        step.role        = ROLE_NONE;
        unique case (phase)
            PH_STATUS_START:
            begin
                if (!is_token(c))
                begin
                    step.status = ST_MALFORMED;
                end
                else
                begin
                    step.phase = PH_STATUS;
                    step.role  = ROLE_STATUS;
                end
            end
            PH_STATUS:
            begin
                if (c == CHAR_CR)
                begin
                    step.phase = PH_LF_STATUS;
                end
                else
                begin
                    step.role = ROLE_STATUS;
                end
            end
            PH_LF_STATUS, PH_LF_LINE:
            begin
                if (c != CHAR_LF)
                begin
                    step.status = ST_MALFORMED;
                end
                else
                begin
                    step.phase = PH_LINE_START;
                end
            end
            PH_LINE_START:
            begin
                if (c == CHAR_CR)
                begin
                    step.phase = PH_LF_END;
                end
                else if (header_seen && (c == CHAR_SP || c == CHAR_HT))
                begin
                    step.phase = PH_LWS;
                end
                else if (!is_token(c))
                begin
                    step.status = ST_MALFORMED;
                end
                else
                begin
                    step.header_seen = 1'b1;
                    step.phase       = PH_NAME;
                    step.role        = ROLE_NAME_FIRST;
                end
            end
            PH_LWS:
            begin
                if (c == CHAR_CR)
                begin
                    step.phase = PH_LF_LINE;
                end
                else if (c == CHAR_SP || c == CHAR_HT)
                begin
                    step.phase = PH_LWS;
                end
                else if (is_ctl(c))
                begin
                    step.status = ST_MALFORMED;
                end
                else
                begin
                    step.phase = PH_VALUE;
                    step.role  = ROLE_VALUE;
                end
            end
            PH_NAME:
            begin
                if (c == CHAR_COLON)
                begin
                    step.phase = PH_SPACE;
                end
                else if (!is_token(c))
                begin
                    step.status = ST_MALFORMED;
                end
                else
                begin
                    step.role = ROLE_NAME;
                end
            end
            PH_SPACE:
            begin
                if (c != CHAR_SP)
                begin
                    step.status = ST_MALFORMED;
                end
                else
                begin
                    step.phase = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                if (c == CHAR_CR)
                begin
                    step.phase = PH_LF_LINE;
                end
                else if (is_ctl(c))
                begin
                    step.status = ST_MALFORMED;
                end
                else
                begin
                    step.role = ROLE_VALUE;
                end
            end
            PH_LF_END:
            begin
                step.status = (c == CHAR_LF) ? ST_COMPLETE : ST_MALFORMED;
            end
            default:
            begin
                step.status = ST_MALFORMED;
            end
        endcase
    end

endmodule

### design/http_response_header_parser.sv
// Top level of the HTTP response header parser.
// Depends on hrp_pkg, hrp_if (channel interfaces) and hrp_step.
//
// Usage: response bytes arrive one per request on in_bytes; every byte gives
// exactly one request on results carrying the parse status, the role of the
// byte and the byte itself. The cfg channel writes the byte limit; it is
// always ready and is meant to be written only while the parser is idle.
//
// A byte accepted on in_bytes is first held in the input register; its result
// is then registered in the output register, where results.valid goes high.
// The parser takes one byte per cycle while the receiver does not stall, as
// every byte updates the parse state once.
//
// Once a complete, malformed or too-large outcome has been reported, the
// parser keeps returning it for every further byte until reset.
// Reset clears the parse state, the byte count and the outcome, empties both
// registers and sets the byte limit to 65536.
// When the receiver stalls, the result register holds and the input register
// can still take one byte; in_bytes.ready drops only when both are full.
module http_response_header_parser (
    input  logic          clk,
    input  logic          rst_n,
    hrp_cfg_if.sink       cfg,
    hrp_byte_if.sink      in_bytes,
    hrp_result_if.source  results
);
    import hrp_pkg::*;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [7:0]         in_byte_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            out_status_reg;
    status_t            out_status_next;
    role_t              out_role_reg;
    role_t              out_role_next;
    logic [7:0]         out_byte_reg;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic               header_seen_reg;
    logic               header_seen_next;
    logic [LIMIT_W-1:0] count_reg;
    logic [LIMIT_W-1:0] count_next;
    status_t            final_reg;
    status_t            final_next;
    logic [LIMIT_W-1:0] limit_reg;

    logic               advance;
    logic               in_ready;
    logic               fire;
    step_t              step;

    hrp_step u_step (
        .phase       (phase_reg),
        .header_seen (header_seen_reg),
        .c           (in_byte_reg),
        .step        (step)
    );

    assign advance  = !out_valid_reg || results.ready;
    assign in_ready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    assign cfg.ready      = 1'b1;
    assign in_bytes.ready = in_ready;

    assign results.valid        = out_valid_reg;
    assign results.parse_status = out_status_reg;
    assign results.byte_role    = out_role_reg;
    assign results.byte_out     = out_byte_reg;

    assign in_valid_next  = in_ready ? in_bytes.valid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        header_seen_next = header_seen_reg;
        count_next       = count_reg;
        final_next       = final_reg;
        out_status_next  = final_reg;
        out_role_next    = ROLE_NONE;
        if (fire)
        begin
            priority if (final_reg != ST_INCOMPLETE)
            begin
                out_status_next = final_reg;
            end
            else if (count_reg >= limit_reg)
            begin
                out_status_next = ST_TOO_LARGE;
                final_next      = ST_TOO_LARGE;
            end
            else
            begin
                // A malformed byte is still counted.
                count_next       = count_reg + {{(LIMIT_W-1){1'b0}}, 1'b1};
                phase_next       = step.phase;
                header_seen_next = step.header_seen;
                out_status_next  = step.status;
                out_role_next    = step.role;
                final_next       = step.status;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_STATUS_START;
            header_seen_reg <= 1'b0;
            count_reg       <= '0;
            final_reg       <= ST_INCOMPLETE;
            limit_reg       <= LIMIT_RESET;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            phase_reg       <= phase_next;
            header_seen_reg <= header_seen_next;
            count_reg       <= count_next;
            final_reg       <= final_next;
            if (cfg.valid)
            begin
                limit_reg <= cfg.byte_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_bytes.valid)
        begin
            in_byte_reg <= in_bytes.data_byte;
        end
        if (fire)
        begin
            out_status_reg <= out_status_next;
            out_role_reg   <= out_role_next;
            out_byte_reg   <= in_byte_reg;
        end
    end

endmodule

### design/hrp_checker.sv
// Port-level checks for the HTTP response header parser, attached to the
// top level by the bind statement below. Depends on hrp_pkg.
module hrp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] parse_status,
    input logic [2:0] byte_role,
    input logic [7:0] byte_out
);
    import hrp_pkg::*;

    logic out_fire;

    assign out_fire = out_valid && out_ready;

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(parse_status)
            && $stable(byte_role) && $stable(byte_out))
        else $error("stalled result changed");

    // Input is refused only while a finished result waits at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused without output stall");

    // Any final outcome carries no role.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_status != ST_INCOMPLETE |-> byte_role == ROLE_NONE)
        else $error("final outcome with a byte role");

    // A final outcome stays latched for the next result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && parse_status != ST_INCOMPLETE) ##1 out_fire
            |-> parse_status == $past(parse_status))
        else $error("final outcome not latched");

    // An accepted byte passes the input register and then shows up as a result,
    // or joins a result that is already waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("accepted byte left no result");

endmodule

bind http_response_header_parser hrp_checker u_hrp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_bytes.valid),
    .in_ready     (in_bytes.ready),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .parse_status (results.parse_status),
    .byte_role    (results.byte_role),
    .byte_out     (results.byte_out)
);

### tb/sv/tb_http_response_header_parser.sv
// Self-checking testbench for http_response_header_parser: byte requests in,
// tagged result requests out, compared against an in-bench parser model.
// Depends on hrp_pkg, the hrp channel interfaces and the parser top level.
module tb_http_response_header_parser;
    import hrp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        status_t    status;
        role_t      role;
        logic [7:0] data;
    } parse_result_t;

    logic clk = 1'b0;
    logic rst_n;

    hrp_byte_if   in_bus ();
    hrp_result_if res_bus ();
    hrp_cfg_if    cfg_bus ();

    http_response_header_parser DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_bus),
        .in_bytes (in_bus),
        .results  (res_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Parser model state, starting from the reset values.
    phase_t      model_phase     = PH_STATUS_START;
    logic        model_hdr_seen  = 1'b0;
    logic [23:0] model_consumed  = '0;
    status_t     model_outcome   = ST_INCOMPLETE;
    logic [23:0] model_limit     = LIMIT_RESET;

    parse_result_t pending_results[$];
    int            mismatches  = 0;
    int            sent_bytes  = 0;
    int            cycle_count = 0;
    bit            idle_on     = 1'b1;
    int            stall_left  = 0;

    function automatic logic is_ctrl_char(input logic [7:0] c);
        return (c < 8'd32) || (c == CHAR_DEL);
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        case (c)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]",
            "?", "=", "{", "}", CHAR_SP, CHAR_HT:
                hit = 1'b1;
            default:
                hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return (c < 8'd128) && !is_ctrl_char(c) && !is_delim(c);
    endfunction

    // Applies one byte to the model and returns the result it must produce.
    function automatic parse_result_t predict_byte(input logic [7:0] c);
        parse_result_t r;
        r.data   = c;
        r.role   = ROLE_NONE;
        r.status = ST_INCOMPLETE;
        if (model_outcome != ST_INCOMPLETE)
        begin
            r.status = model_outcome;
        end
        else if (model_consumed >= model_limit)
        begin
            r.status      = ST_TOO_LARGE;
            model_outcome = ST_TOO_LARGE;
        end
        else
        begin
            model_consumed = model_consumed + 24'd1;
            case (model_phase)
                PH_STATUS_START:
                begin
                    if (!is_name_char(c))
                    begin
                        r.status = ST_MALFORMED;
                    end
                    else
                    begin
                        model_phase = PH_STATUS;
                        r.role      = ROLE_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    if (c == CHAR_CR) model_phase = PH_LF_STATUS;
                    else r.role = ROLE_STATUS;
                end
                PH_LF_STATUS, PH_LF_LINE:
                begin
                    if (c != CHAR_LF) r.status = ST_MALFORMED;
                    else model_phase = PH_LINE_START;
                end
                PH_LINE_START:
                begin
                    if (c == CHAR_CR)
                    begin
                        model_phase = PH_LF_END;
                    end
                    else if (model_hdr_seen && (c == CHAR_SP || c == CHAR_HT))
                    begin
                        model_phase = PH_LWS;
                    end
                    else if (!is_name_char(c))
                    begin
                        r.status = ST_MALFORMED;
                    end
                    else
                    begin
                        model_hdr_seen = 1'b1;
                        model_phase    = PH_NAME;
                        r.role         = ROLE_NAME_FIRST;
                    end
                end
                PH_LWS:
                begin
                    if (c == CHAR_CR)
                    begin
                        model_phase = PH_LF_LINE;
                    end
                    else if (c == CHAR_SP || c == CHAR_HT)
                    begin
                        r.status = ST_INCOMPLETE;
                    end
                    else if (is_ctrl_char(c))
                    begin
                        r.status = ST_MALFORMED;
                    end
                    else
                    begin
                        model_phase = PH_VALUE;
                        r.role      = ROLE_VALUE;
                    end
                end
                PH_NAME:
                begin
                    if (c == CHAR_COLON) model_phase = PH_SPACE;
                    else if (!is_name_char(c)) r.status = ST_MALFORMED;
                    else r.role = ROLE_NAME;
                end
                PH_SPACE:
                begin
                    if (c != CHAR_SP) r.status = ST_MALFORMED;
                    else model_phase = PH_VALUE;
                end
                PH_VALUE:
                begin
                    if (c == CHAR_CR) model_phase = PH_LF_LINE;
                    else if (is_ctrl_char(c)) r.status = ST_MALFORMED;
                    else r.role = ROLE_VALUE;
                end
                PH_LF_END:
                begin
                    r.status = (c == CHAR_LF) ? ST_COMPLETE : ST_MALFORMED;
                end
                default:
                begin
                    r.status = ST_MALFORMED;
                end
            endcase
            model_outcome = r.status;
        end
        return r;
    endfunction

    function automatic logic [7:0] rand_token();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 127)); while (!is_name_char(b));
        return b;
    endfunction

    function automatic logic [7:0] rand_value_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(32, 255)); while (b == CHAR_DEL);
        return b;
    endfunction

    // First byte of a continuation value: any byte above SP except DEL.
    function automatic logic [7:0] rand_value_lead();
        logic [7:0] b;
        do b = 8'($urandom_range(33, 255)); while (b == CHAR_DEL);
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        parse_result_t expected;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.data_byte <= b;
        do @(posedge clk); while (in_bus.ready !== 1'b1);
        expected = predict_byte(b);
        pending_results.insert(pending_results.size(), expected);
        sent_bytes++;
    endtask

    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_byte_limit(input logic [23:0] v);
        wait_drained();
        cfg_bus.valid      <= 1'b1;
        cfg_bus.byte_limit <= v;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        cfg_bus.valid <= 1'b0;
        model_limit = v;
    endtask

    // One well-formed header line, sometimes followed by continuation lines.
    task automatic send_header_line();
        int n_cont;
        send_byte(rand_token());
        repeat ($urandom_range(0, 6)) send_byte(rand_token());
        send_byte(CHAR_COLON);
        send_byte(CHAR_SP);
        repeat ($urandom_range(0, 10)) send_byte(rand_value_byte());
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        n_cont = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n_cont)
        begin
            repeat ($urandom_range(1, 3))
                send_byte($urandom_range(0, 1) ? CHAR_SP : CHAR_HT);
            if ($urandom_range(0, 4) != 0)
            begin
                send_byte(rand_value_lead());
                repeat ($urandom_range(0, 8)) send_byte(rand_value_byte());
            end
            send_byte(CHAR_CR);
            send_byte(CHAR_LF);
        end
    endtask

    task automatic test_directed_stream();
        logic [7:0] seq [26];
        // Status line with extreme bytes, a header with token extremes and a
        // high byte in the value, a continuation after HT SP, an empty one.
        seq = '{8'h48, 8'hFF, 8'h00, 8'h80, 8'h7F, CHAR_LF, 8'h31, CHAR_CR, CHAR_LF,
                8'h7E, 8'h21, CHAR_COLON, CHAR_SP, 8'hFF, CHAR_SP, 8'h7B,
                CHAR_CR, CHAR_LF,
                CHAR_HT, CHAR_SP, 8'h80, CHAR_CR, CHAR_LF,
                CHAR_SP, CHAR_CR, CHAR_LF};
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    // No byte is sent while the limit sits below the count.
    task automatic test_limit_settings();
        write_byte_limit(24'd0);
        write_byte_limit(24'd1);
        write_byte_limit(24'hFFFFFF);
    endtask

    task automatic test_random_headers(input int n_bytes);
        int start_count;
        int next_cfg;
        start_count = sent_bytes;
        next_cfg    = sent_bytes + 350;
        while (sent_bytes - start_count < n_bytes)
        begin
            send_header_line();
            if (sent_bytes >= next_cfg)
            begin
                next_cfg = sent_bytes + 350;
                case ($urandom_range(0, 2))
                    0: write_byte_limit(24'hFFFFFF);
                    1: write_byte_limit(LIMIT_RESET);
                    default: write_byte_limit(
                        24'(model_consumed + $urandom_range(2000, 60000)));
                endcase
            end
        end
    endtask

    task automatic test_malformed_line();
        logic [7:0] b;
        case ($urandom_range(0, 6))
            0:
            begin
                do b = 8'($urandom); while (is_name_char(b) || b == CHAR_CR ||
                                            b == CHAR_SP || b == CHAR_HT);
                send_byte(b);
            end
            1:
            begin
                send_byte(rand_token());
                do b = 8'($urandom); while (is_name_char(b) || b == CHAR_COLON);
                send_byte(b);
            end
            2:
            begin
                send_byte(rand_token());
                send_byte(CHAR_COLON);
                do b = 8'($urandom); while (b == CHAR_SP);
                send_byte(b);
            end
            3:
            begin
                send_byte(rand_token());
                send_byte(CHAR_COLON);
                send_byte(CHAR_SP);
                send_byte(rand_value_byte());
                do b = 8'($urandom_range(0, 32)); while (b == CHAR_CR);
                send_byte((b == 8'd32) ? CHAR_DEL : b);
            end
            4:
            begin
                send_byte(rand_token());
                send_byte(CHAR_COLON);
                send_byte(CHAR_SP);
                send_byte(CHAR_CR);
                do b = 8'($urandom); while (b == CHAR_LF);
                send_byte(b);
            end
            5:
            begin
                send_byte(CHAR_CR);
                do b = 8'($urandom); while (b == CHAR_LF);
                send_byte(b);
            end
            default:
            begin
                send_byte(CHAR_SP);
                do b = 8'($urandom_range(0, 31)); while (b == CHAR_CR);
                send_byte(b);
            end
        endcase
    endtask

    // Exactly one final outcome is reachable per run, since reset is not repeated.
    task automatic test_terminal_outcome();
        case ($urandom_range(0, 3))
            0:
            begin
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            1: test_malformed_line();
            2:
            begin
                write_byte_limit(24'(model_consumed + $urandom_range(0, 3)));
                send_header_line();
            end
            default:
            begin
                write_byte_limit($urandom_range(0, 1) ? 24'd0
                                 : 24'($urandom_range(0, model_consumed)));
                send_byte(rand_token());
            end
        endcase
    endtask

    task automatic test_latched_tail(input int n_bytes);
        repeat (n_bytes) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                res_bus.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && rst_n && $urandom_range(0, 5) == 0)
            begin
                res_bus.ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
            begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        parse_result_t want;
        if (rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d role %0d byte %02h",
                             res_bus.parse_status, res_bus.byte_role, res_bus.byte_out);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_bus.parse_status !== want.status || res_bus.byte_role !== want.role ||
                    res_bus.byte_out !== want.data)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected status %0d role %0d byte %02h, got %0d %0d %02h",
                                 want.status, want.role, want.data, res_bus.parse_status,
                                 res_bus.byte_role, res_bus.byte_out);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("http_response_header_parser verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n              <= 1'b0;
        in_bus.valid       <= 1'b0;
        in_bus.data_byte   <= 8'h00;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.byte_limit <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_stream();
        test_limit_settings();
        test_random_headers(1400);
        // Neither side idles from here on.
        idle_on = 1'b0;
        test_terminal_outcome();
        test_latched_tail(60);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("http_response_header_parser verification clean");
        else
            $display("http_response_header_parser verification failed");
        $finish;
    end

endmodule
